/* hdl/sd_data_block_receive_crc16_top_defines.svh */
// Assertion macros for the SD data block receiver.
// Included by the top level; no other dependencies.
`ifndef SD_DATA_BLOCK_RECEIVE_CRC16_TOP_DEFINES_SVH
`define SD_DATA_BLOCK_RECEIVE_CRC16_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define SDBR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sdbr assertion failed");

// Next-cycle implication, checked out of reset
`define SDBR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sdbr assertion failed");

`else

`define SDBR_ASSERT_NOW(lbl, ante, cons)
`define SDBR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* hdl/sdbr_pkg.sv */
// Shared types, codes and the CRC-16-CCITT byte update for the SD data block receiver.
// No dependencies.
package sdbr_pkg;

    // Field widths
    localparam int BLK_LEN_W = 13;
    localparam int TIMEOUT_W = 16;
    localparam int BYTE_W    = 8;
    localparam int CRC_W     = 16;
    localparam int STATUS_W  = 2;

    localparam int SDBR_MAX_BLOCK_BYTES = 4096;

    // Register file
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam logic [1:0] REG_BLOCK_LENGTH = 2'd0;
    localparam logic [1:0] REG_TIMEOUT      = 2'd1;
    localparam logic [1:0] REG_START_TOKEN  = 2'd2;

    localparam logic [BLK_LEN_W-1:0] RST_BLOCK_LENGTH = 13'd512;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT      = 16'd8;
    localparam logic [BYTE_W-1:0]    RST_START_TOKEN  = 8'hFE;

    localparam logic [BYTE_W-1:0] IDLE_BYTE = 8'hFF;

    // Item codes
    localparam logic OP_ARM  = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADTOKEN = 2'd3;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic [BLK_LEN_W-1:0] block_length;
        logic [TIMEOUT_W-1:0] timeout_bytes;
        logic [BYTE_W-1:0]    start_token;
    } t_cfg;

    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   data_byte;
        logic [STATUS_W-1:0] status;
        logic [CRC_W-1:0]    received_crc;
        logic [CRC_W-1:0]    computed_crc;
        logic                last;
    } t_result;

    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } t_outq_stat;

    // CRC-16-CCITT, MSB first, one byte per call
    function automatic logic [CRC_W-1:0] sdbr_crc_byte(input logic [CRC_W-1:0] crc,
                                                       input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hdl/sdbr_regs.sv */
// APB configuration registers: block length, idle timeout, start token.
// Depends on sdbr_pkg.
module sdbr_regs import sdbr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    logic wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_length  <= RST_BLOCK_LENGTH;
            r_cfg.timeout_bytes <= RST_TIMEOUT;
            r_cfg.start_token   <= RST_START_TOKEN;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BLOCK_LENGTH: r_cfg.block_length  <= pwdata[BLK_LEN_W-1:0];
                REG_TIMEOUT:      r_cfg.timeout_bytes <= pwdata[TIMEOUT_W-1:0];
                REG_START_TOKEN:  r_cfg.start_token   <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_BLOCK_LENGTH: prdata = APB_DATA_W'(r_cfg.block_length);
            REG_TIMEOUT:      prdata = APB_DATA_W'(r_cfg.timeout_bytes);
            REG_START_TOKEN:  prdata = APB_DATA_W'(r_cfg.start_token);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/sdbr_core.sv */
// Block receive sequencer: token hunt with timeout, payload pass-through with CRC, CRC check.
// Depends on sdbr_pkg.
module sdbr_core import sdbr_pkg::*; #(
    parameter int MAX_BLOCK_BYTES = SDBR_MAX_BLOCK_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_opcode,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  t_cfg              i_cfg,
    output logic              o_res_valid,
    output t_result           o_res
);

    localparam int CNT_W = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int LEN_W = (CNT_W > BLK_LEN_W) ? CNT_W : BLK_LEN_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BLOCK_BYTES);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_WAIT   = 3'd1;
    localparam logic [2:0] PH_DATA   = 3'd2;
    localparam logic [2:0] PH_CRC_HI = 3'd3;
    localparam logic [2:0] PH_CRC_LO = 3'd4;

    logic [2:0]           r_phase, n_phase;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [TIMEOUT_W-1:0] r_idle, n_idle;
    logic [CRC_W-1:0]     r_crc, n_crc;
    logic [CRC_W-1:0]     r_crc_rx, n_crc_rx;

    logic [LEN_W-1:0]     blen_ext;
    logic [LEN_W-1:0]     eff_len;
    logic [CNT_W-1:0]     cnt_inc;
    logic [TIMEOUT_W-1:0] idle_inc;
    logic [CRC_W-1:0]     crc_upd;
    logic [CRC_W-1:0]     crc_full;

    // Effective block length: zero counts as one, clipped to the maximum
    always_comb begin
        blen_ext = LEN_W'(i_cfg.block_length);
        if (blen_ext == '0) begin
            eff_len = LEN_W'(1);
        end else if (blen_ext > MAX_LEN) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = blen_ext;
        end
    end

    assign cnt_inc  = r_count + CNT_W'(1);
    assign idle_inc = (r_idle != '1) ? r_idle + TIMEOUT_W'(1) : r_idle;
    assign crc_upd  = sdbr_crc_byte(r_crc, i_rx_byte);
    assign crc_full = {r_crc_rx[CRC_W-1:BYTE_W], i_rx_byte};

    // Next state and result for the item in the input register
    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_idle      = r_idle;
        n_crc       = r_crc;
        n_crc_rx    = r_crc_rx;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_fire) begin
            if (i_opcode == OP_ARM) begin
                n_phase  = PH_WAIT;
                n_count  = '0;
                n_idle   = '0;
                n_crc    = '0;
                n_crc_rx = '0;
            end else begin
                case (r_phase)
                    PH_WAIT: begin
                        if (i_rx_byte == IDLE_BYTE) begin
                            n_idle = idle_inc;
                            if (i_cfg.timeout_bytes != '0 && idle_inc >= i_cfg.timeout_bytes) begin
                                n_phase      = PH_IDLE;
                                o_res_valid  = 1'b1;
                                o_res.kind   = KIND_STATUS;
                                o_res.status = ST_TIMEOUT;
                                o_res.last   = 1'b1;
                            end
                        end else if (i_rx_byte != i_cfg.start_token) begin
                            n_phase      = PH_IDLE;
                            o_res_valid  = 1'b1;
                            o_res.kind   = KIND_STATUS;
                            o_res.status = ST_BADTOKEN;
                            o_res.last   = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                            n_count = '0;
                            n_crc   = '0;
                        end
                    end
                    PH_DATA: begin
                        n_crc   = crc_upd;
                        n_count = cnt_inc;
                        if (LEN_W'(cnt_inc) >= eff_len) begin
                            n_phase = PH_CRC_HI;
                        end
                        o_res_valid     = 1'b1;
                        o_res.kind      = KIND_DATA;
                        o_res.data_byte = i_rx_byte;
                    end
                    PH_CRC_HI: begin
                        n_crc_rx = {i_rx_byte, 8'h00};
                        n_phase  = PH_CRC_LO;
                    end
                    PH_CRC_LO: begin
                        n_crc_rx           = crc_full;
                        n_phase            = PH_IDLE;
                        o_res_valid        = 1'b1;
                        o_res.kind         = KIND_STATUS;
                        o_res.status       = (crc_full == r_crc) ? ST_OK : ST_MISMATCH;
                        o_res.received_crc = crc_full;
                        o_res.computed_crc = r_crc;
                        o_res.last         = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_count  <= '0;
            r_idle   <= '0;
            r_crc    <= '0;
            r_crc_rx <= '0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_idle   <= n_idle;
            r_crc    <= n_crc;
            r_crc_rx <= n_crc_rx;
        end
    end

endmodule

/* hdl/sdbr_outq.sv */
// Result register with a one-entry skid stage that parks a result while the receiver stalls.
// Depends on sdbr_pkg.
module sdbr_outq import sdbr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_res_valid,
    input  t_result    i_res,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output t_result    o_out,
    output t_outq_stat o_stat
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // Skid entry drains first; the core does not fire while it is full
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (i_res_valid) begin
                n_out       = i_res;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_res_valid) begin
            n_skid       = i_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;
    assign o_stat.out_valid  = r_out_valid;
    assign o_stat.skid_valid = r_skid_valid;

endmodule

/* hdl/sd_data_block_receive_crc16_top.sv */
// SD SPI-mode data block receiver with CRC-16-CCITT check.
// Input channel: i_in_valid / o_in_stall with i_opcode (arm or card byte) and i_rx_byte.
// Output channel: o_out_valid / i_out_stall with one item per payload byte and one final
// status item (ok, crc mismatch, timeout, bad start token); ok and mismatch carry both CRCs.
// Configuration through the APB port: block_length at 0x0, timeout_bytes at 0x4,
// start_token at 0x8; write only while no transfer is in flight.
// An accepted item is held in the input register and its result is registered in the
// result register, or in the skid stage while the receiver stalls.
// Throughput: one item per cycle while the skid stage is empty; the byte-wide CRC update
// and sequencer step are combinational between the input and result registers.
// When the receiver stalls, one further result parks in the skid stage; the input
// stalls only while that stage and the input register are both full.
// Reset (synchronous, active low) clears the sequencer to not armed, empties both
// channels and restores the register defaults (512, 8, 0xFE).
// Depends on sdbr_pkg, sdbr_regs, sdbr_core, sdbr_outq and the assertion macro header.
`include "sd_data_block_receive_crc16_top_defines.svh"
module sd_data_block_receive_crc16_top import sdbr_pkg::*; #(
    parameter int MAX_BLOCK_BYTES = SDBR_MAX_BLOCK_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_opcode,
    input  logic [BYTE_W-1:0]     i_rx_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_kind,
    output logic [BYTE_W-1:0]     o_data_byte,
    output logic [STATUS_W-1:0]   o_status,
    output logic [CRC_W-1:0]      o_received_crc,
    output logic [CRC_W-1:0]      o_computed_crc,
    output logic                  o_last
);

    t_cfg        cfg;
    t_result     res;
    t_result     out_item;
    t_outq_stat  oq_stat;
    logic        res_valid;
    logic        fire;
    logic        in_accept;

    logic              r_in_valid;
    logic              r_in_opcode;
    logic [BYTE_W-1:0] r_in_byte;

    sdbr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input register; it drains whenever the skid stage has room
    assign fire       = r_in_valid && !oq_stat.skid_valid;
    assign o_in_stall = r_in_valid && oq_stat.skid_valid;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_opcode <= i_opcode;
            r_in_byte   <= i_rx_byte;
        end
    end

    sdbr_core #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_opcode    (r_in_opcode),
        .i_rx_byte   (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sdbr_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (out_item),
        .o_stat      (oq_stat)
    );

    assign o_kind         = out_item.kind;
    assign o_data_byte    = out_item.data_byte;
    assign o_status       = out_item.status;
    assign o_received_crc = out_item.received_crc;
    assign o_computed_crc = out_item.computed_crc;
    assign o_last         = out_item.last;

    // Checks
    `SDBR_ASSERT_NOW(a_skid_needs_out, oq_stat.skid_valid, oq_stat.out_valid)
    `SDBR_ASSERT_NEXT(a_skid_drains, oq_stat.skid_valid && !i_out_stall, o_out_valid && !oq_stat.skid_valid)
    `SDBR_ASSERT_NOW(a_data_not_last, o_out_valid && o_kind == KIND_DATA, !o_last && o_status == ST_OK)
    `SDBR_ASSERT_NOW(a_err_no_crc, o_out_valid && (o_status == ST_TIMEOUT || o_status == ST_BADTOKEN), o_received_crc == '0 && o_computed_crc == '0)

endmodule
